// ===== sv/dsil_pkg.sv =====
// Package of shared types and constants for the depth-sorted insert list.
`timescale 1ns / 1ps
package dsil_pkg;
    localparam int CAPACITY  = 1024;
    localparam int KEY_BITS  = 24;
    localparam int TAG_BITS  = 16;
    localparam int IDX_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture the accepted item
        logic search_rd; // read the key at the search midpoint
        logic search;    // one binary search compare step
        logic shift_rd;  // read the entry below the shift destination
        logic shift;     // move one entry up a place
        logic write;     // store the new entry at the found position
        logic rd_issue;  // read the requested entry
        logic finish;    // build the result register
        logic clear;     // empty the list
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        t_op  op;
        logic full;
        logic search_done;
        logic shift_done;
    } t_sts;
endpackage

// ===== sv/dsil_datapath.sv =====
// Datapath of the depth-sorted insert list: entry memories, search bounds and shifter.
`timescale 1ns / 1ps
module dsil_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dsil_pkg::t_cmd         i_cmd,
    output dsil_pkg::t_sts         o_sts,
    input  logic [1:0]             i_opcode,
    input  logic [23:0]            i_depth_key,
    input  logic [15:0]            i_tag,
    input  logic [9:0]             i_read_index,
    output logic [9:0]             o_slot,
    output logic                   o_full_res,
    output logic [23:0]            o_read_key,
    output logic [15:0]            o_read_tag,
    output logic [10:0]            o_count
);
    import dsil_pkg::*;

    logic [KEY_BITS-1:0] mem_key [CAPACITY];
    logic [TAG_BITS-1:0] mem_tag [CAPACITY];

    logic [1:0]          r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic [9:0]          r_ridx;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] r_lo, r_hi;
    logic [CNT_BITS-1:0] r_sh;      // destination index of the next shift
    logic [KEY_BITS-1:0] r_rd_key;
    logic [TAG_BITS-1:0] r_rd_tag;
    logic                r_rd_ok;
    logic                r_full;
    logic [KEY_BITS-1:0] r_mid_key;
    logic [KEY_BITS-1:0] r_mv_key;
    logic [TAG_BITS-1:0] r_mv_tag;

    logic [CNT_BITS-1:0] mid;
    logic [IDX_BITS-1:0] mid_i, sh_i, shm_i, ridx_i;
    logic                mid_le;

    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign mid_i  = mid[IDX_BITS-1:0];
    assign sh_i   = r_sh[IDX_BITS-1:0];
    assign shm_i  = IDX_BITS'(r_sh - CNT_BITS'(1));
    assign ridx_i = IDX_BITS'(r_ridx);
    // The midpoint key is read into a register in the cycle before it is compared.
    assign mid_le = r_key <= r_mid_key;

    assign o_sts.op          = t_op'(r_op);
    assign o_sts.full        = r_count >= CNT_BITS'(CAPACITY);
    assign o_sts.search_done = !(r_lo < r_hi);
    assign o_sts.shift_done  = !(r_sh > r_lo);

    always_ff @(posedge i_clk) begin
        if (i_cmd.search_rd) begin
            r_mid_key <= mem_key[mid_i];
        end
        if (i_cmd.shift_rd) begin
            r_mv_key <= mem_key[shm_i];
            r_mv_tag <= mem_tag[shm_i];
        end
        if (i_cmd.shift) begin
            mem_key[sh_i] <= r_mv_key;
            mem_tag[sh_i] <= r_mv_tag;
        end else if (i_cmd.write) begin
            mem_key[r_lo[IDX_BITS-1:0]] <= r_key;
            mem_tag[r_lo[IDX_BITS-1:0]] <= r_tag;
        end
        if (i_cmd.rd_issue) begin
            r_rd_key <= mem_key[ridx_i];
            r_rd_tag <= mem_tag[ridx_i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.write) begin
                r_count <= r_count + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_key  <= i_depth_key;
            r_tag  <= i_tag;
            r_ridx <= i_read_index;
            r_lo   <= '0;
            r_hi   <= r_count;
            r_sh   <= r_count;
            r_rd_ok <= CNT_BITS'(i_read_index) < r_count;
            r_full <= o_sts.full;
        end
        if (i_cmd.search) begin
            if (mid_le) r_hi <= mid;
            else        r_lo <= mid + CNT_BITS'(1);
        end
        if (i_cmd.shift) r_sh <= r_sh - CNT_BITS'(1);
        if (i_cmd.finish) begin
            o_slot     <= '0;
            o_full_res <= 1'b0;
            o_read_key <= '0;
            o_read_tag <= '0;
            o_count    <= 11'(r_count);
            case (t_op'(r_op))
                OP_INSERT: begin
                    // Fullness is taken from the count before the insert.
                    o_full_res <= r_full;
                    if (!r_full) o_slot <= 10'(r_lo);
                end
                OP_READ: begin
                    if (r_rd_ok) begin
                        o_read_key <= r_rd_key;
                        o_read_tag <= r_rd_tag;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== sv/dsil_ctrl.sv =====
// Controller state machine of the depth-sorted insert list.
`timescale 1ns / 1ps
module dsil_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output dsil_pkg::t_cmd  o_cmd,
    input  dsil_pkg::t_sts  i_sts
);
    import dsil_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_SEARCH = 9'b000000100,
        S_CMP    = 9'b000001000,
        S_SHIFT  = 9'b000010000,
        S_MOVE   = 9'b000100000,
        S_READ   = 9'b001000000,
        S_FINISH = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_OUT;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_FINISH;
                    end
                    OP_INSERT: n_state = i_sts.full ? S_FINISH : S_SEARCH;
                    OP_READ: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_READ;
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_SEARCH: begin
                if (i_sts.search_done) begin
                    n_state = S_SHIFT;
                end else begin
                    o_cmd.search_rd = 1'b1;
                    n_state         = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.search = 1'b1;
                n_state      = S_SEARCH;
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_FINISH;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state        = S_MOVE;
                end
            end
            S_MOVE: begin
                o_cmd.shift = 1'b1;
                n_state     = S_SHIFT;
            end
            S_READ: n_state = S_FINISH;
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

// ===== sv/depth_sorted_insert_list_unit.sv =====
// Top level of the depth-sorted insert list.
//  channel | direction | content
//  s_axis  | in        | tdata: opcode, depth_key, tag, read_index
//  m_axis  | out       | tdata: slot, full_res, read_key, read_tag, count
// A clear, a refused insert or an unused opcode passes the decode and finish states before
// its result is offered, a read the read state as well. An insert spends a search and a
// compare state on each search step (at most ten) and a shift and a move state on every
// entry above the found slot, since each move reads the memory into a register and writes
// it back in the move state; then it writes the new entry. One item is worked on at a time.
// Reset empties the list; the entries themselves are not cleared.
// A result waits in its register until the master side takes the transfer.
`timescale 1ns / 1ps
module depth_sorted_insert_list_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], depth_key[25:2], tag[41:26], read_index[51:42], zero pad
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // slot[9:0], full_res[10], read_key[34:11], read_tag[50:35], count[61:51]
    output logic [63:0] m_axis_tdata
);
    import dsil_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [9:0]  slot;
    logic        full_res;
    logic [23:0] read_key;
    logic [15:0] read_tag;
    logic [10:0] count;

    dsil_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd), .i_sts(sts)
    );

    dsil_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_opcode(s_axis_tdata[1:0]), .i_depth_key(s_axis_tdata[25:2]),
        .i_tag(s_axis_tdata[41:26]), .i_read_index(s_axis_tdata[51:42]),
        .o_slot(slot), .o_full_res(full_res), .o_read_key(read_key),
        .o_read_tag(read_tag), .o_count(count)
    );

    assign m_axis_tdata = {2'b00, count, read_tag, read_key, full_res, slot};
endmodule

// ===== test/dsil_checker.sv =====
// Checker for the depth-sorted insert list: predicts each result and compares it.
`timescale 1ns / 1ps
module dsil_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [55:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_out_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import dsil_pkg::*;

    typedef struct packed {
        logic [CNT_BITS-1:0] count;
        logic [TAG_BITS-1:0] read_tag;
        logic [KEY_BITS-1:0] read_key;
        logic                full_res;
        logic [IDX_BITS-1:0] slot;
    } t_result;

    logic [KEY_BITS-1:0] key_store [CAPACITY];
    logic [TAG_BITS-1:0] tag_store [CAPACITY];
    int                  held;
    t_result             expected_q [$];

    // Works out the result of one item and updates the shadow list.
    function automatic t_result apply_item(logic [55:0] d);
        t_op                 op;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        int                  ridx;
        int                  lo;
        int                  hi;
        int                  mid;
        t_result             r;
        op   = t_op'(d[1:0]);
        key  = d[25:2];
        tag  = d[41:26];
        ridx = d[51:42];
        r    = '0;
        case (op)
            OP_CLEAR: held = 0;
            OP_INSERT: begin
                if (held >= CAPACITY) begin
                    r.full_res = 1'b1;
                end else begin
                    lo = 0;
                    hi = held;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (key <= key_store[mid]) hi = mid;
                        else lo = mid + 1;
                    end
                    for (int i = held; i > lo; i--) begin
                        key_store[i] = key_store[i-1];
                        tag_store[i] = tag_store[i-1];
                    end
                    key_store[lo] = key;
                    tag_store[lo] = tag;
                    held++;
                    r.slot = lo[IDX_BITS-1:0];
                end
            end
            OP_READ: begin
                if (ridx < held) begin
                    r.read_key = key_store[ridx];
                    r.read_tag = tag_store[ridx];
                end
            end
            default: ;
        endcase
        r.count = held[CNT_BITS-1:0];
        return r;
    endfunction

    task automatic report(string field, longint unsigned exp_v, longint unsigned act_v);
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, field, exp_v, act_v);
        o_fail_count++;
    endtask

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_result exp_r;
        t_result act_r;
        if (!i_rst_n) begin
            held = 0;
            o_fail_count = 0;
            o_checked    = 0;
            expected_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) expected_q.push_back(apply_item(i_in_data));
            if (i_out_valid && i_out_ready) begin
                act_r = t_result'(i_out_data[61:0]);
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result transfer 0x%0h", $time, i_out_data);
                    o_fail_count++;
                end else begin
                    exp_r = expected_q.pop_front();
                    o_checked++;
                    if (act_r.slot != exp_r.slot) report("slot", exp_r.slot, act_r.slot);
                    if (act_r.full_res != exp_r.full_res)
                        report("full_res", exp_r.full_res, act_r.full_res);
                    if (act_r.read_key != exp_r.read_key)
                        report("read_key", exp_r.read_key, act_r.read_key);
                    if (act_r.read_tag != exp_r.read_tag)
                        report("read_tag", exp_r.read_tag, act_r.read_tag);
                    if (act_r.count != exp_r.count) report("count", exp_r.count, act_r.count);
                    if (i_out_data[63:62] != 2'b00) report("padding", 0, i_out_data[63:62]);
                end
            end
        end
    end
endmodule

// ===== test/tb_depth_sorted_insert_list_unit.sv =====
// Testbench top for the depth-sorted insert list: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_depth_sorted_insert_list_unit;
    import dsil_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    int fail_count;
    int pending;
    int checked;
    int quiet_cycles = 0;
    bit calm = 1'b0;
    int list_len = 0;
    int n_insert = 0;
    int n_refused = 0;
    int n_read = 0;
    int n_clear = 0;

    always #2 i_clk = ~i_clk;

    depth_sorted_insert_list_unit u_top (.*);

    dsil_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Result side back-pressure, switched off while the calm stretch runs.
    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 23);
    end

    // Watchdog: cycles in which no transfer happens on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else if (i_rst_n)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
            $display("depth_sorted_insert_list_unit test failed");
            $finish;
        end
    end

    task automatic send(t_op op, logic [KEY_BITS-1:0] key, logic [TAG_BITS-1:0] tag,
                        logic [IDX_BITS-1:0] ridx);
        while (!calm && $urandom_range(99) < 23) @(negedge i_clk);
        s_axis_tdata  = {4'b0, ridx, tag, key, op};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        case (op)
            OP_CLEAR: begin
                list_len = 0;
                n_clear++;
            end
            OP_INSERT: begin
                if (list_len < CAPACITY) list_len++;
                else n_refused++;
                n_insert++;
            end
            OP_READ: n_read++;
            default: ;
        endcase
    endtask

    initial begin
        int roll;
        logic [KEY_BITS-1:0] key;
        logic [IDX_BITS-1:0] ridx;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty reads, unused opcode, extreme and equal keys.
        send(OP_READ, '0, '0, '0);
        send(OP_READ, '1, '1, '1);
        send(OP_NONE, '1, '1, '1);
        send(OP_INSERT, '0, 16'h1111, '1);
        send(OP_INSERT, '1, 16'hFFFF, '0);
        send(OP_INSERT, '0, 16'h2222, '0);
        send(OP_INSERT, 24'h800000, 16'h0000, '0);
        send(OP_INSERT, '1, 16'h5A5A, '0);
        for (int i = 0; i < 6; i++) send(OP_READ, '0, '0, i[IDX_BITS-1:0]);
        send(OP_NONE, '0, '0, '0);
        send(OP_CLEAR, '1, '1, '1);
        send(OP_READ, '0, '0, '0);

        // Fill to capacity in ascending order so no entry has to move, then overflow.
        for (int i = 0; i < CAPACITY; i++)
            send(OP_INSERT, KEY_BITS'(i * 16000), TAG_BITS'($urandom), '0);
        send(OP_INSERT, '0, 16'hDEAD, '0);
        send(OP_INSERT, '1, 16'hBEEF, '0);
        send(OP_READ, '0, '0, '1);
        send(OP_READ, '0, '0, '0);
        send(OP_READ, '0, '0, 10'd512);
        send(OP_CLEAR, '0, '0, '0);

        // Random frames: mostly inserts and reads within the list, the odd clear.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 60 && i < 140);
            roll = $urandom_range(99);
            if (roll < 3 || list_len > 200) begin
                send(OP_CLEAR, KEY_BITS'($urandom), TAG_BITS'($urandom), IDX_BITS'($urandom));
            end else if (roll < 58) begin
                // Narrow key ranges give plenty of equal keys.
                key = ($urandom_range(1) == 0) ? KEY_BITS'($urandom_range(15)) :
                                                 KEY_BITS'($urandom);
                send(OP_INSERT, key, TAG_BITS'($urandom), IDX_BITS'($urandom));
            end else if (roll < 93) begin
                ridx = ($urandom_range(9) == 0) ? IDX_BITS'($urandom) :
                                                  IDX_BITS'($urandom_range(list_len + 1));
                send(OP_READ, KEY_BITS'($urandom), TAG_BITS'($urandom), ridx);
            end else begin
                send(OP_NONE, KEY_BITS'($urandom), TAG_BITS'($urandom), IDX_BITS'($urandom));
            end
        end
        calm = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);

        $display("Covered %0d inserts (%0d refused on a full list), %0d reads and %0d clears;",
                 n_insert, n_refused, n_read, n_clear);
        $display("%0d results compared against the predicted list contents.", checked);
        if (fail_count == 0 && pending == 0)
            $display("depth_sorted_insert_list_unit test passed");
        else
            $display("depth_sorted_insert_list_unit test failed");
        $finish;
    end
endmodule
